// ===== hdl/tfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfb_pkg
// Types and constants shared by the telemetry frame builder modules.
// ----------------------------------------------------------------------------
package tfb_pkg;

	// Largest payload length that a frame start may announce.
	localparam logic [7:0] MAX_PAYLOAD = 8'd128;

	// A single item gives at most five results: two sync bytes, id, length and checksum.
	localparam int NUM_SLOTS = 5;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);

	// Width of the configuration register index.
	localparam int CFG_INDEX_W = 4;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_SYNC_HIGH = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_SYNC_LOW  = CFG_INDEX_W'(1);

	// Reset values of the sync registers.
	localparam logic [7:0] SYNC_HIGH_RESET = 8'd235;
	localparam logic [7:0] SYNC_LOW_RESET  = 8'd144;

	typedef enum logic {
		OP_START = 1'b0,
		OP_DATA  = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ERR_OK        = 2'd0,
		ERR_IDLE_DATA = 2'd1,
		ERR_TOO_LONG  = 2'd2,
		ERR_BUSY      = 2'd3
	} err_t;

	// All results of one item: bytes in emission order, the result count,
	// whether the final result closes the frame, and the error code.
	typedef struct packed {
		logic [NUM_SLOTS-1:0][7:0] bytes;
		logic [SLOT_W-1:0]         count;
		logic                      closes;
		err_t                      err;
	} run_t;

endpackage

// ===== hdl/telemetry_frame_builder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_frame_builder_unit
// Serializes telemetry frames (sync, sync, id, length, payload, XOR checksum)
// into a byte stream, one result per output transfer.
//
//   channel | signals                                          | direction
//   --------+--------------------------------------------------+----------
//   input   | in_valid/in_ready, opcode, message_id,           | in
//           | payload_length, data_byte                        |
//   output  | out_valid/out_ready, out_byte, byte_present,     | out
//           | frame_end, run_last, error_code                  |
//   config  | cfg_valid/cfg_ready, cfg_index, cfg_data         | in
//
// Results appear from the cycle after the item's transfer, one per ready cycle.
// A data item or an error gives one result, a closing data item gives two,
// a frame start four or five; the core sets this count in the run.
// A new item is taken in the cycle that the last result of the previous run
// is transferred; single-result items stream at one per cycle if unstalled.
// Reset clears the frame state and loads the default sync bytes.
// ----------------------------------------------------------------------------
module telemetry_frame_builder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            opcode,
	input  logic [7:0]                      message_id,
	input  logic [7:0]                      payload_length,
	input  logic [7:0]                      data_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      out_byte,
	output logic                            byte_present,
	output logic                            frame_end,
	output logic                            run_last,
	output logic [1:0]                      error_code,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [tfb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data
);
	import tfb_pkg::*;

	run_t run;
	logic take;

	assign cfg_ready = 1'b1;
	assign take      = in_valid && in_ready;

	// Frame state and result generation.
	tfb_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.opcode         (opcode),
		.message_id     (message_id),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.cfg_take       (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.run            (run)
	);

	// Result run register and output sequencing.
	tfb_emitter u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.run          (run),
		.load         (take),
		.can_load     (in_ready),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.byte_present (byte_present),
		.frame_end    (frame_end),
		.run_last     (run_last),
		.error_code   (error_code)
	);

	// An error result is always alone and carries no byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (error_code != ERR_OK) |-> run_last && !byte_present && !frame_end)
		else $error("error result is not a lone empty result");

	// The closing checksum is always the final result of its run.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_last && byte_present)
		else $error("frame end outside the last result of a run");

	// No new item is taken while a run still has results to give.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !run_last |-> !in_ready)
		else $error("input taken in the middle of a run");

	// A result not yet transferred stays in place for the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("pending result changed before transfer");

endmodule

// ===== hdl/tfb_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfb_core
// Frame state and sync registers; turns one input item into its result run.
// ----------------------------------------------------------------------------
module tfb_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  logic                            opcode,
	input  logic [7:0]                      message_id,
	input  logic [7:0]                      payload_length,
	input  logic [7:0]                      data_byte,
	input  logic                            cfg_take,
	input  logic [tfb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [7:0]                      cfg_data,
	output tfb_pkg::run_t                   run
);
	import tfb_pkg::*;

	logic       frame_open_q;
	logic [7:0] bytes_remaining_q;
	logic [7:0] running_checksum_q;
	logic [7:0] sync_high_q;
	logic [7:0] sync_low_q;

	logic       frame_open_d;
	logic [7:0] bytes_remaining_d;
	logic [7:0] running_checksum_d;
	logic [7:0] start_ck;
	logic [7:0] data_ck;
	logic [7:0] data_rem;

	assign start_ck = message_id ^ payload_length;
	assign data_ck  = running_checksum_q ^ data_byte;
	assign data_rem = bytes_remaining_q - 8'd1;

	// Result run and next frame state for the item at the input.
	always_comb begin
		run                = '0;
		run.count          = SLOT_W'(1);
		run.err            = ERR_OK;
		frame_open_d       = frame_open_q;
		bytes_remaining_d  = bytes_remaining_q;
		running_checksum_d = running_checksum_q;
		if (opcode_t'(opcode) == OP_START) begin
			if (frame_open_q) begin
				run.err = ERR_BUSY;
			end else if (payload_length > MAX_PAYLOAD) begin
				run.err = ERR_TOO_LONG;
			end else begin
				run.bytes[0] = sync_high_q;
				run.bytes[1] = sync_low_q;
				run.bytes[2] = message_id;
				run.bytes[3] = payload_length;
				run.bytes[4] = start_ck;
				if (payload_length == 8'd0) begin
					// Empty payload: the checksum closes the frame at once.
					run.count          = SLOT_W'(5);
					run.closes         = 1'b1;
					running_checksum_d = 8'd0;
				end else begin
					run.count          = SLOT_W'(4);
					frame_open_d       = 1'b1;
					bytes_remaining_d  = payload_length;
					running_checksum_d = start_ck;
				end
			end
		end else begin
			if (!frame_open_q) begin
				run.err = ERR_IDLE_DATA;
			end else begin
				run.bytes[0]      = data_byte;
				run.bytes[1]      = data_ck;
				bytes_remaining_d = data_rem;
				if (data_rem == 8'd0) begin
					run.count          = SLOT_W'(2);
					run.closes         = 1'b1;
					frame_open_d       = 1'b0;
					running_checksum_d = 8'd0;
				end else begin
					running_checksum_d = data_ck;
				end
			end
		end
	end

	// Frame state advances on each input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q       <= 1'b0;
			bytes_remaining_q  <= 8'd0;
			running_checksum_q <= 8'd0;
		end else if (take) begin
			frame_open_q       <= frame_open_d;
			bytes_remaining_q  <= bytes_remaining_d;
			running_checksum_q <= running_checksum_d;
		end
	end

	// Sync byte registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_high_q <= SYNC_HIGH_RESET;
			sync_low_q  <= SYNC_LOW_RESET;
		end else if (cfg_take) begin
			if (cfg_index == REG_SYNC_HIGH) begin
				sync_high_q <= cfg_data;
			end
			if (cfg_index == REG_SYNC_LOW) begin
				sync_low_q <= cfg_data;
			end
		end
	end

endmodule

// ===== hdl/tfb_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfb_emitter
// Holds one result run and hands its results out one per transfer.
// ----------------------------------------------------------------------------
module tfb_emitter (
	input  logic          clk,
	input  logic          arst_n,
	input  tfb_pkg::run_t run,
	input  logic          load,
	output logic          can_load,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          byte_present,
	output logic          frame_end,
	output logic          run_last,
	output logic [1:0]    error_code
);
	import tfb_pkg::*;

	run_t              run_s1;
	logic              valid_s1;
	logic [SLOT_W-1:0] idx_q;
	logic              last;
	logic              sent;

	assign last     = (idx_q == run_s1.count - SLOT_W'(1));
	assign sent     = valid_s1 && out_ready;
	assign can_load = !valid_s1 || (sent && last);

	// Run register and result index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			valid_s1 <= 1'b1;
			idx_q    <= '0;
		end else if (sent) begin
			if (last) begin
				valid_s1 <= 1'b0;
			end else begin
				idx_q <= idx_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			run_s1 <= run;
		end
	end

	// Fields of the current result.
	always_comb begin
		out_valid    = valid_s1;
		out_byte     = (32'(idx_q) < NUM_SLOTS) ? run_s1.bytes[idx_q] : 8'd0;
		byte_present = (run_s1.err == ERR_OK);
		frame_end    = last && run_s1.closes;
		run_last     = last;
		error_code   = run_s1.err;
	end

endmodule

// ===== sim/telemetry_frame_builder_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_frame_builder_unit_test
// Self-checking bench for the telemetry frame builder. A behavioral frame
// predictor tracks the open frame, the remaining payload count, the running
// XOR checksum and the sync registers, and queues the result bytes that each
// accepted input transfer should produce. A checker compares every output
// transfer against the oldest queued result. Stimulus covers directed misuse
// cases, sync register settings, a long frame under a long output stall,
// and random frame traffic with random idling on both channels.
// ----------------------------------------------------------------------------
module telemetry_frame_builder_unit_test;

	import tfb_pkg::*;

	// Register indexes that map to no register; writes to them must be dropped.
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_LOW = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_TOP = '1;

	// Cycles the output side is held off during the back-pressure test.
	localparam int LONG_HOLD     = 150;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_LIMIT  = 60;

	// Payload length of the frame sent against the long output hold.
	localparam logic [7:0] PRESSURE_LEN = 8'd24;
	// Input items offered by the random traffic test.
	localparam int RANDOM_ITEMS = 40;

	// One result byte as it should appear on the output channel.
	typedef struct packed {
		logic [7:0] byte_val;
		logic       present;
		logic       closes;
		logic       last;
		err_t       err;
	} frame_beat_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic                   opcode;
	logic [7:0]             message_id;
	logic [7:0]             payload_length;
	logic [7:0]             data_byte;
	logic                   out_valid;
	logic                   out_ready;
	logic [7:0]             out_byte;
	logic                   byte_present;
	logic                   frame_end;
	logic                   run_last;
	logic [1:0]             error_code;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [7:0]             cfg_data;

	// Predictor state: frame tracking and the sync register copies.
	logic       frame_open;
	logic [7:0] bytes_left;
	logic [7:0] frame_checksum;
	logic [7:0] sync_hi;
	logic [7:0] sync_lo;

	frame_beat_t expected_beats[$];

	bit idle_on;
	int hold_request;
	int fail_count;
	int items_sent;
	int beats_checked;
	int frames_closed;
	int error_beats;

	telemetry_frame_builder_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.message_id     (message_id),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.byte_present   (byte_present),
		.frame_end      (frame_end),
		.run_last       (run_last),
		.error_code     (error_code),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Prints one mismatch line and counts it; output is capped to keep logs short.
	task automatic flag_mismatch(input string what);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%0t ns: mismatch: %s", $time, what);
	endtask

	// Queues one expected result byte.
	function automatic void push_beat(input logic [7:0] b, input logic present,
			input logic closes, input logic last, input err_t err);
		frame_beat_t beat;
		beat.byte_val = b;
		beat.present  = present;
		beat.closes   = closes;
		beat.last     = last;
		beat.err      = err;
		expected_beats.push_back(beat);
		if (err != ERR_OK)
			error_beats++;
		if (closes)
			frames_closed++;
	endfunction

	// Works out the results of one accepted item and advances the frame state.
	function automatic void predict_frame_beats(input opcode_t op, input logic [7:0] id,
			input logic [7:0] len, input logic [7:0] data);
		logic [7:0] ck;
		if (op == OP_START) begin
			if (frame_open) begin
				push_beat(8'h00, 1'b0, 1'b0, 1'b1, ERR_BUSY);
			end else if (len > MAX_PAYLOAD) begin
				push_beat(8'h00, 1'b0, 1'b0, 1'b1, ERR_TOO_LONG);
			end else begin
				ck = id ^ len;
				push_beat(sync_hi, 1'b1, 1'b0, 1'b0, ERR_OK);
				push_beat(sync_lo, 1'b1, 1'b0, 1'b0, ERR_OK);
				push_beat(id, 1'b1, 1'b0, 1'b0, ERR_OK);
				push_beat(len, 1'b1, 1'b0, len != 8'd0, ERR_OK);
				if (len == 8'd0) begin
					// An empty payload closes the frame right after the header.
					push_beat(ck, 1'b1, 1'b1, 1'b1, ERR_OK);
					frame_checksum = 8'd0;
				end else begin
					frame_open     = 1'b1;
					bytes_left     = len;
					frame_checksum = ck;
				end
			end
		end else if (!frame_open) begin
			push_beat(8'h00, 1'b0, 1'b0, 1'b1, ERR_IDLE_DATA);
		end else begin
			frame_checksum = frame_checksum ^ data;
			bytes_left     = bytes_left - 8'd1;
			push_beat(data, 1'b1, 1'b0, bytes_left != 8'd0, ERR_OK);
			if (bytes_left == 8'd0) begin
				push_beat(frame_checksum, 1'b1, 1'b1, 1'b1, ERR_OK);
				frame_open     = 1'b0;
				frame_checksum = 8'd0;
			end
		end
	endfunction

	// Offers one item, after a random gap when idling is on, and waits for its transfer.
	task automatic send_item(input opcode_t op, input logic [7:0] id,
			input logic [7:0] len, input logic [7:0] data);
		int gap;
		gap = idle_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid       <= 1'b1;
		opcode         <= op;
		message_id     <= id;
		payload_length <= len;
		data_byte      <= data;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		predict_frame_beats(op, id, len, data);
	endtask

	// Writes one register; the valid stays up when another write follows.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val,
			input bit final_write);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		if (final_write)
			cfg_valid <= 1'b0;
		if (idx == REG_SYNC_HIGH)
			sync_hi = val;
		else if (idx == REG_SYNC_LOW)
			sync_lo = val;
	endtask

	// Stops offering input and waits until every queued result has arrived.
	task automatic drain_results();
		int waited;
		waited = 0;
		in_valid <= 1'b0;
		while (expected_beats.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_beats.size() != 0) begin
			flag_mismatch($sformatf("%0d expected results never arrived",
				expected_beats.size()));
			expected_beats.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Sends a complete frame with random id and payload.
	task automatic send_frame(input logic [7:0] len);
		int i;
		send_item(OP_START, 8'($urandom), len, 8'($urandom));
		for (i = 0; i < len; i++)
			send_item(OP_DATA, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// Misuse cases, empty payloads, oversize lengths and short frames.
	task automatic test_protocol_errors();
		idle_on = 1'b1;
		send_item(OP_DATA, 8'h00, 8'h00, 8'hFF);
		send_item(OP_DATA, 8'hFF, 8'hFF, 8'h00);
		send_item(OP_START, 8'hFF, 8'h00, 8'h00);
		send_item(OP_START, 8'h00, 8'h00, 8'hFF);
		send_item(OP_START, 8'h12, MAX_PAYLOAD + 8'd1, 8'h00);
		send_item(OP_START, 8'hFF, 8'hFF, 8'hFF);
		// Single-byte frame: the byte and the checksum come from one item.
		send_item(OP_START, 8'hA5, 8'h01, 8'h00);
		send_item(OP_DATA, 8'h00, 8'h00, 8'hFF);
		// A start inside an open frame is refused, even with an oversize length.
		send_item(OP_START, 8'h5A, 8'h03, 8'h00);
		send_item(OP_START, 8'h00, 8'h00, 8'h00);
		send_item(OP_START, 8'hFF, 8'hFF, 8'hFF);
		send_item(OP_DATA, 8'hFF, 8'hFF, 8'h00);
		send_item(OP_DATA, 8'h00, 8'h00, 8'h80);
		send_item(OP_DATA, 8'h00, 8'h00, 8'h7F);
		send_item(OP_DATA, 8'h00, 8'h00, 8'h3C);
		send_item(OP_START, 8'h81, 8'h02, 8'h00);
		send_item(OP_DATA, 8'h00, 8'h00, 8'hAA);
		send_item(OP_DATA, 8'h00, 8'h00, 8'h55);
		drain_results();
	endtask

	// Several sync settings, extremes included, plus writes to unmapped indexes.
	task automatic test_sync_registers();
		int s;
		int f;
		logic [7:0] hi;
		logic [7:0] lo;
		for (s = 0; s < 5; s++) begin
			case (s)
				0: begin
					hi = 8'h00;
					lo = 8'h00;
				end
				1: begin
					hi = 8'hFF;
					lo = 8'hFF;
				end
				2: begin
					hi = 8'h00;
					lo = 8'hFF;
				end
				default: begin
					hi = 8'($urandom);
					lo = 8'($urandom);
				end
			endcase
			idle_on = (s != 2);
			write_reg(REG_SYNC_HIGH, hi, 1'b0);
			write_reg(REG_SYNC_LOW, lo, s != 1);
			if (s == 1) begin
				write_reg(REG_UNUSED_TOP, 8'h00, 1'b0);
				write_reg(REG_UNUSED_LOW, 8'h00, 1'b1);
			end
			for (f = 0; f < 3; f++)
				send_frame(8'($urandom_range(0, 4)));
			drain_results();
		end
	endtask

	// A long frame offered back to back while the output is held off.
	task automatic test_backpressure_full_frame();
		idle_on      = 1'b0;
		hold_request = LONG_HOLD;
		send_frame(PRESSURE_LEN);
		drain_results();
		idle_on = 1'b1;
	endtask

	// Mostly well-formed frames with random content, mixed with stray bytes,
	// oversize starts and starts that land inside an open frame.
	task automatic test_random_traffic();
		int stop_at;
		int pick;
		int len;
		int i;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			idle_on = ($urandom_range(0, 3) != 0);
			pick    = $urandom_range(0, 9);
			if (pick == 0) begin
				send_item(OP_DATA, 8'($urandom), 8'($urandom), 8'($urandom));
			end else if (pick == 1) begin
				send_item(OP_START, 8'($urandom),
					8'($urandom_range(int'(MAX_PAYLOAD) + 1, 255)), 8'($urandom));
			end else begin
				len = (pick == 9) ? $urandom_range(9, 16) : $urandom_range(0, 8);
				send_item(OP_START, 8'($urandom), 8'(len), 8'($urandom));
				for (i = 0; i < len; i++) begin
					if ($urandom_range(0, 11) == 0)
						send_item(OP_START, 8'($urandom), 8'($urandom), 8'($urandom));
					send_item(OP_DATA, 8'($urandom), 8'($urandom), 8'($urandom));
				end
			end
		end
		drain_results();
	endtask

	// Output side: random stall after each transfer when idling is on, or a long hold on request.
	initial begin : output_sink
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				stall_left   = hold_request;
				hold_request = 0;
			end else if (out_valid && out_ready) begin
				stall_left = idle_on ? $urandom_range(0, 9) : 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compares each output transfer with the oldest expected result.
	always @(posedge clk) begin
		frame_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			beats_checked++;
			if (expected_beats.size() == 0) begin
				flag_mismatch($sformatf(
					"unexpected result: byte %02h present %0b end %0b last %0b err %0d",
					out_byte, byte_present, frame_end, run_last, error_code));
			end else begin
				want = expected_beats.pop_front();
				if (out_byte !== want.byte_val || byte_present !== want.present ||
						frame_end !== want.closes || run_last !== want.last ||
						error_code !== want.err)
					flag_mismatch($sformatf({"got byte %02h p%0b e%0b l%0b err %0d, ",
						"want byte %02h p%0b e%0b l%0b err %0d"},
						out_byte, byte_present, frame_end, run_last, error_code,
						want.byte_val, want.present, want.closes, want.last, want.err));
			end
		end
	end

	// Watchdog for a hung block.
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Test sequence.
	initial begin
		arst_n         = 1'b0;
		in_valid       <= 1'b0;
		opcode         <= OP_START;
		message_id     <= 8'h00;
		payload_length <= 8'h00;
		data_byte      <= 8'h00;
		cfg_valid      <= 1'b0;
		cfg_index      <= REG_SYNC_HIGH;
		cfg_data       <= 8'h00;
		frame_open     = 1'b0;
		bytes_left     = 8'd0;
		frame_checksum = 8'd0;
		sync_hi        = SYNC_HIGH_RESET;
		sync_lo        = SYNC_LOW_RESET;
		idle_on        = 1'b1;
		hold_request   = 0;
		fail_count     = 0;
		items_sent     = 0;
		beats_checked  = 0;
		frames_closed  = 0;
		error_beats    = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_protocol_errors();
		test_sync_registers();
		test_backpressure_full_frame();
		test_random_traffic();

		$display("Sent %0d items: %0d frames closed, %0d error results, five sync settings.",
			items_sent, frames_closed, error_beats);
		$display("Checked %0d output transfers under random stalls and a %0d-cycle hold.",
			beats_checked, LONG_HOLD);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== telemetry_frame_builder_unit.f =====
hdl/tfb_pkg.sv
hdl/tfb_core.sv
hdl/tfb_emitter.sv
hdl/telemetry_frame_builder_unit.sv
sim/telemetry_frame_builder_unit_test.sv
